@@ design/fbm_pkg.sv @@
package fbm_pkg;

	// Fixed field widths
	localparam int LSN_W  = 10;
	localparam int DATA_W = 16;
	localparam int CNT_W  = 32;
	// Remainder width covers the largest block size (256 sectors)
	localparam int REM_W  = 8;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_BLOCKS        = 16;
	localparam int DEF_SECTORS_PER_BLOCK = 32;

	// Action codes
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Status codes
	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;

	typedef struct packed {
		logic              action;
		logic [LSN_W-1:0]  logical_sector;
		logic [DATA_W-1:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [DATA_W-1:0] read_data;
		logic              sector_erased;
		logic [CNT_W-1:0]  write_total;
		logic [CNT_W-1:0]  erase_total;
	} res_t;

	// Divider status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [LSN_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_res_t;

endpackage

@@ design/fbm_div.sv @@
// Division by a constant through a reciprocal multiply. The dividend is latched
// on start, the quotient is registered from it, and then the remainder and done.
module fbm_div #(
	parameter int DIVISOR = fbm_pkg::DEF_SECTORS_PER_BLOCK
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fbm_pkg::LSN_W-1:0] dividend,
	output fbm_pkg::div_res_t        res
);

	localparam int LSN_W  = fbm_pkg::LSN_W;
	localparam int REM_W  = fbm_pkg::REM_W;
	// Shift of LSN_W + ceil(log2(DIVISOR)) keeps the quotient exact for every
	// LSN_W-bit dividend
	localparam int SHIFT  = LSN_W + $clog2(DIVISOR);
	localparam int PROD_W = SHIFT + LSN_W;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'((1 << SHIFT) / DIVISOR + 1);
	localparam logic [LSN_W-1:0]  DIV_L = LSN_W'(DIVISOR);
	localparam logic [REM_W:0]    DIV_V = (REM_W + 1)'(DIVISOR);

	logic [LSN_W-1:0] dvd_q;
	logic [LSN_W-1:0] quot_q;
	logic [REM_W-1:0] rem_q;
	logic             mul_q;   // dividend latched, quotient due
	logic             sub_q;   // quotient ready, remainder due
	logic             done_q;

	logic [PROD_W-1:0] prod;
	logic [LSN_W-1:0]  back;
	logic [LSN_W-1:0]  diff;

	always_comb begin
		prod = {{SHIFT{1'b0}}, dvd_q} * RECIP;
		back = quot_q * DIV_L;
		diff = dvd_q - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			mul_q  <= 1'b0;
			sub_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start;
			sub_q  <= mul_q && !start;
			done_q <= sub_q && !start;
			if (start) begin
				dvd_q <= dividend;
			end
			if (mul_q) begin
				quot_q <= prod[SHIFT +: LSN_W];
			end
			if (sub_q) begin
				rem_q <= diff[REM_W-1:0];
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && (mul_q || sub_q)))
		else $error("divider started while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rem_q} < DIV_V)
		else $error("remainder not below divisor");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(sub_q))
		else $error("done without a division in progress");
`endif

endmodule

@@ design/flash_block_mapping_ftl.sv @@
// Block-mapped flash translation layer with one hidden spare block. Each cmd
// transaction is a sector read or write at a logical sector number; each one
// returns exactly one res transaction carrying status, read data, the erased
// flag and the running program and erase totals. The logical sector is split
// into block and offset by a constant reciprocal multiply. A read or an
// in-place write then needs a map read and a sector read; an address error
// skips both. An overwrite goes through the sector store: copy a block,
// erase a block, and when the spare must first be reclaimed, one more copy
// and erase before that.
// cmd_stall is high for the whole time an item is in work. After reset a
// clearing pass marks every sector erased and loads the identity block map;
// cmd_stall stays high during it. A finished result waits in the output
// register, so the next cmd can be taken while res is stalled.
module flash_block_mapping_ftl #(
	parameter int NUM_BLOCKS        = fbm_pkg::DEF_NUM_BLOCKS,
	parameter int SECTORS_PER_BLOCK = fbm_pkg::DEF_SECTORS_PER_BLOCK
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  fbm_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output fbm_pkg::res_t res
);

	localparam int LSN_W   = fbm_pkg::LSN_W;
	localparam int DATA_W  = fbm_pkg::DATA_W;
	localparam int CNT_W   = fbm_pkg::CNT_W;
	localparam int WORD_W  = DATA_W + 1;
	localparam int PB_W    = $clog2(NUM_BLOCKS + 1);
	localparam int OFF_W   = $clog2(SECTORS_PER_BLOCK);
	localparam int ADDR_W  = PB_W + OFF_W;
	localparam int MAP_IW  = $clog2(NUM_BLOCKS);
	localparam int SC_W    = $clog2(SECTORS_PER_BLOCK + 1);
	localparam int STORE_WORDS = (NUM_BLOCKS + 1) << OFF_W;

	// Physical block index of the spare
	localparam logic [PB_W-1:0]   SPARE       = PB_W'(NUM_BLOCKS);
	// Bit DATA_W set marks an erased sector
	localparam logic [WORD_W-1:0] ERASED_WORD = WORD_W'(1) << DATA_W;

	// Sequencer states
	localparam logic [3:0] S_INIT       = 4'd0;
	localparam logic [3:0] S_IDLE       = 4'd1;
	localparam logic [3:0] S_DIV        = 4'd2;
	localparam logic [3:0] S_MAP        = 4'd3;
	localparam logic [3:0] S_SEC        = 4'd4;
	localparam logic [3:0] S_RECLAIM    = 4'd5;  // spare -> free block, whole
	localparam logic [3:0] S_ER_SPARE_A = 4'd6;
	localparam logic [3:0] S_MOVE       = 4'd7;  // old block -> spare, new data merged
	localparam logic [3:0] S_ER_OLD     = 4'd8;
	localparam logic [3:0] S_BACK       = 4'd9;  // spare -> free block, new data merged
	localparam logic [3:0] S_ER_SPARE_B = 4'd10;
	localparam logic [3:0] S_DONE       = 4'd11;

	logic [3:0] state_q;

	// Control state
	logic [ADDR_W-1:0] clr_q;
	logic [SC_W-1:0]   cnt_q;
	logic              cp_vld_s1;
	logic [OFF_W-1:0]  cp_off_s1;
	logic              busy_q;     // spare holds a logical block
	logic [PB_W-1:0]   free_q;
	logic [MAP_IW-1:0] disp_q;
	logic [CNT_W-1:0]  prog_q;
	logic [CNT_W-1:0]  erase_q;
	logic              res_valid_q;

	// Item payload
	fbm_pkg::cmd_t     cmd_q;
	logic [LSN_W-1:0]  lbn_q;
	logic [OFF_W-1:0]  off_q;
	logic [PB_W-1:0]   pb_q;
	logic              rslt_status_q;
	logic [DATA_W-1:0] rslt_rdata_q;
	logic              rslt_erased_q;
	fbm_pkg::res_t     res_q;

	// Memories
	logic [WORD_W-1:0] store_mem [STORE_WORDS];
	logic [PB_W-1:0]   map_mem [NUM_BLOCKS];
	logic [WORD_W-1:0] st_rd_q;
	logic [PB_W-1:0]   map_rd_q;

	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	logic [WORD_W-1:0] st_wdata;
	logic [ADDR_W-1:0] st_raddr;
	logic              map_we;
	logic [MAP_IW-1:0] map_waddr;
	logic [PB_W-1:0]   map_wdata;
	logic [MAP_IW-1:0] map_raddr;

	// Divider
	fbm_pkg::div_res_t div_res;
	logic              div_start;

	// Decode
	logic              is_copy;
	logic [PB_W-1:0]   cp_src;
	logic [PB_W-1:0]   cp_dst;
	logic              cp_merge;
	logic [PB_W-1:0]   er_blk;
	logic              cp_end;
	logic              er_end;
	logic              addr_err;
	logic              is_write;
	logic              sec_erased;
	logic              done_load;

	assign div_start = (state_q == S_IDLE) && cmd_valid;

	fbm_div #(
		.DIVISOR(SECTORS_PER_BLOCK)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(cmd.logical_sector),
		.res     (div_res)
	);

	always_comb begin
		is_copy  = (state_q == S_RECLAIM) || (state_q == S_MOVE) || (state_q == S_BACK);
		cp_src   = (state_q == S_MOVE) ? pb_q : SPARE;
		cp_dst   = (state_q == S_MOVE) ? SPARE : free_q;
		cp_merge = (state_q != S_RECLAIM);
		er_blk   = (state_q == S_ER_OLD) ? pb_q : SPARE;
		cp_end   = (cnt_q == SC_W'(SECTORS_PER_BLOCK));
		er_end   = (cnt_q == SC_W'(SECTORS_PER_BLOCK - 1));
		is_write = (cmd_q.action == fbm_pkg::ACT_WRITE);
		// Block 0 may not be read: a read of block 0 is an address error
		addr_err = ({1'b0, div_res.quot} >= (LSN_W + 1)'(NUM_BLOCKS)) ||
			(!is_write && (div_res.quot == '0));
		sec_erased = st_rd_q[DATA_W];
		done_load  = (state_q == S_DONE) && (!res_valid_q || !res_stall);
	end

	// Memory port steering
	always_comb begin
		st_we     = 1'b0;
		st_waddr  = '0;
		st_wdata  = ERASED_WORD;
		st_raddr  = {cp_src, cnt_q[OFF_W-1:0]};
		map_we    = 1'b0;
		map_waddr = '0;
		map_wdata = '0;
		map_raddr = div_res.quot[MAP_IW-1:0];
		case (state_q)
			S_INIT: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				if (clr_q < ADDR_W'(NUM_BLOCKS)) begin
					map_we    = 1'b1;
					map_waddr = clr_q[MAP_IW-1:0];
					map_wdata = clr_q[PB_W-1:0];
				end
			end
			S_MAP: begin
				st_raddr = {map_rd_q, off_q};
			end
			S_SEC: begin
				if (is_write && sec_erased) begin
					st_we    = 1'b1;
					st_waddr = {pb_q, off_q};
					st_wdata = {1'b0, cmd_q.write_data};
				end
			end
			S_RECLAIM, S_MOVE, S_BACK: begin
				if (cp_vld_s1) begin
					st_we    = 1'b1;
					st_waddr = {cp_dst, cp_off_s1};
					st_wdata = (cp_merge && (cp_off_s1 == off_q)) ?
						{1'b0, cmd_q.write_data} : st_rd_q;
				end
				if (cp_end && (state_q == S_RECLAIM)) begin
					map_we    = 1'b1;
					map_waddr = disp_q;
					map_wdata = free_q;
				end
				if (cp_end && (state_q == S_BACK)) begin
					map_we    = 1'b1;
					map_waddr = lbn_q[MAP_IW-1:0];
					map_wdata = free_q;
				end
			end
			S_ER_SPARE_A, S_ER_OLD, S_ER_SPARE_B: begin
				st_we    = 1'b1;
				st_waddr = {er_blk, cnt_q[OFF_W-1:0]};
				if (er_end && (state_q == S_ER_OLD)) begin
					map_we    = 1'b1;
					map_waddr = lbn_q[MAP_IW-1:0];
					map_wdata = SPARE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		st_rd_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			cnt_q       <= '0;
			cp_vld_s1   <= 1'b0;
			cp_off_s1   <= '0;
			busy_q      <= 1'b0;
			free_q      <= '0;
			disp_q      <= '0;
			prog_q      <= '0;
			erase_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (done_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= addr_err ? S_DONE : S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_SEC;
				end
				S_SEC: begin
					if (!is_write) begin
						state_q <= S_DONE;
					end else if (sec_erased) begin
						prog_q  <= prog_q + CNT_W'(1);
						state_q <= S_DONE;
					end else if (pb_q == SPARE) begin
						state_q <= S_BACK;
					end else if (busy_q) begin
						state_q <= S_RECLAIM;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_RECLAIM, S_MOVE, S_BACK: begin
					if (!cp_end) begin
						cnt_q     <= cnt_q + SC_W'(1);
						cp_vld_s1 <= 1'b1;
						cp_off_s1 <= cnt_q[OFF_W-1:0];
					end else begin
						cnt_q     <= '0;
						cp_vld_s1 <= 1'b0;
						case (state_q)
							S_RECLAIM: state_q <= S_ER_SPARE_A;
							S_MOVE: begin
								prog_q  <= prog_q + CNT_W'(1);
								state_q <= S_ER_OLD;
							end
							default: begin
								prog_q  <= prog_q + CNT_W'(1);
								state_q <= S_ER_SPARE_B;
							end
						endcase
					end
				end
				S_ER_SPARE_A, S_ER_OLD, S_ER_SPARE_B: begin
					if (!er_end) begin
						cnt_q <= cnt_q + SC_W'(1);
					end else begin
						cnt_q   <= '0;
						erase_q <= erase_q + CNT_W'(1);
						case (state_q)
							S_ER_SPARE_A: state_q <= S_MOVE;
							S_ER_OLD: begin
								free_q  <= pb_q;
								disp_q  <= lbn_q[MAP_IW-1:0];
								busy_q  <= 1'b1;
								state_q <= S_DONE;
							end
							default: begin
								busy_q  <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (done_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			cmd_q <= cmd;
		end
		if ((state_q == S_DIV) && div_res.done) begin
			lbn_q         <= div_res.quot;
			off_q         <= div_res.rem[OFF_W-1:0];
			rslt_status_q <= addr_err ? fbm_pkg::STAT_ERR : fbm_pkg::STAT_OK;
			rslt_rdata_q  <= '0;
			rslt_erased_q <= 1'b0;
		end
		if (state_q == S_MAP) begin
			pb_q <= map_rd_q;
		end
		if ((state_q == S_SEC) && !is_write) begin
			rslt_erased_q <= sec_erased;
			rslt_rdata_q  <= sec_erased ? '0 : st_rd_q[DATA_W-1:0];
		end
		if (done_load) begin
			res_q.status        <= rslt_status_q;
			res_q.read_data     <= rslt_rdata_q;
			res_q.sector_erased <= rslt_erased_q;
			res_q.write_total   <= prog_q;
			res_q.erase_total   <= erase_q;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_free_not_spare: assert property (@(posedge clk) disable iff (!arst_n)
		free_q != SPARE)
		else $error("free block points at the spare");

	a_copy_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(is_copy && st_we) |-> (st_waddr[ADDR_W-1:OFF_W] != st_raddr[ADDR_W-1:OFF_W]))
		else $error("block copy reads and writes the same block");

	a_prog_step: assert property (@(posedge clk) disable iff (!arst_n)
		(prog_q != $past(prog_q)) |-> (prog_q == CNT_W'($past(prog_q) + CNT_W'(1))))
		else $error("program total moved by more than one");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");
`endif

endmodule
